/* design/sbs_pkg.sv */
// ----------------------------------------------------------------------------
// sbs_pkg
// shared constants for the spectrum bar smoother
// ----------------------------------------------------------------------------
`default_nettype none
package sbs_pkg;
    localparam int VALUE_W  = 32;
    localparam int LEVEL_W  = 16;
    localparam int WEIGHT_W = 16;
    localparam int RANGE_W  = VALUE_W + 1;

    localparam logic [WEIGHT_W:0]   WEIGHT_ONE = 17'd65536;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = 16'hFFFF;
    localparam logic [33:0]         ROUND_HALF = 34'd32768;

    localparam logic [WEIGHT_W-1:0] ATTACK_RESET = 16'd52429;
    localparam logic [WEIGHT_W-1:0] DECAY_RESET  = 16'd5243;

    localparam logic CFG_ATTACK = 1'b0;
    localparam logic CFG_DECAY  = 1'b1;
endpackage
`default_nettype wire

/* design/sbs_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// sbs_cmd_fifo
// two-entry command queue between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none
module sbs_cmd_fifo #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    input  wire logic         pop,
    output logic              not_empty,
    output logic              full,
    output logic [W-1:0]      head
);
    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;

    assign not_empty = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !(pop && not_empty))
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && pop && not_empty)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && not_empty)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

/* design/sbs_front.sv */
// ----------------------------------------------------------------------------
// sbs_front
// takes in bins, tracks the running range, frame length and bar cell size
// ----------------------------------------------------------------------------
`default_nettype none
module sbs_front #(
    parameter int MAX_BINS  = 1024,
    parameter int BAR_COUNT = 120,
    parameter int AW        = 10,
    parameter int CW        = 11,
    parameter int CMD_W     = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic signed [31:0] bin_value,
    input  wire logic              last_bin,
    input  wire logic              song_start,
    output logic                   push,
    output logic [CMD_W-1:0]       cmd
);
    import sbs_pkg::*;

    localparam int RW = $clog2(BAR_COUNT);

    typedef struct packed {
        logic                store_en;
        logic [AW-1:0]       addr;
        logic [VALUE_W-1:0]  value;
        logic                frame_en;
        logic [CW-1:0]       len;
        logic [VALUE_W-1:0]  low;
        logic [RANGE_W-1:0]  range;
        logic                clr;
        logic [CW-1:0]       pool_w;
    } cmd_t;

    logic signed [31:0] hi_reg, lo_reg, hi_next, lo_next, h0, l0;
    logic [CW-1:0]      count_reg, count_next, prev_reg;
    logic [CW-1:0]      q_reg, q_next;
    logic [RW-1:0]      r_reg, r_next;
    logic               store;
    cmd_t               c;

    always_comb
    begin
        h0         = song_start ? 32'sd0 : hi_reg;
        l0         = song_start ? 32'sd0 : lo_reg;
        store      = (count_reg < CW'(MAX_BINS));
        hi_next    = h0;
        lo_next    = l0;
        count_next = count_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        if (store)
        begin
            if (bin_value > h0)
            begin
                hi_next = bin_value;
            end
            if (bin_value < l0)
            begin
                lo_next = bin_value;
            end
            count_next = count_reg + CW'(1);
            if (r_reg == RW'(BAR_COUNT - 1))
            begin
                r_next = '0;
                q_next = q_reg + CW'(1);
            end
            else
            begin
                r_next = r_reg + RW'(1);
            end
        end
        c.store_en = store;
        c.addr     = count_reg[AW-1:0];
        c.value    = bin_value;
        c.frame_en = last_bin;
        c.len      = count_next;
        c.low      = lo_next;
        c.range    = {hi_next[31], hi_next} - {lo_next[31], lo_next};
        c.clr      = (count_next != prev_reg);
        c.pool_w   = (q_next == '0) ? CW'(1) : q_next;
    end

    assign push = accept && (store || last_bin);
    assign cmd  = c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg    <= '0;
            lo_reg    <= '0;
            count_reg <= '0;
            prev_reg  <= '0;
            q_reg     <= '0;
            r_reg     <= '0;
        end
        else if (accept)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
            if (last_bin)
            begin
                count_reg <= '0;
                q_reg     <= '0;
                r_reg     <= '0;
                prev_reg  <= count_next;
            end
            else
            begin
                count_reg <= count_next;
                q_reg     <= q_next;
                r_reg     <= r_next;
            end
        end
    end
endmodule
`default_nettype wire

/* design/sbs_back.sv */
// ----------------------------------------------------------------------------
// sbs_back
// stores bins, normalizes and smooths on a nonzero range, pools into bars
// ----------------------------------------------------------------------------
`default_nettype none
module sbs_back #(
    parameter int MAX_BINS  = 1024,
    parameter int BAR_COUNT = 120,
    parameter int AW        = 10,
    parameter int CW        = 11,
    parameter int CMD_W     = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    input  wire logic [CMD_W-1:0]  cmd,
    output logic                   pop,
    input  wire logic [15:0]       attack_weight,
    input  wire logic [15:0]       decay_weight,
    output logic                   result_valid,
    output logic [15:0]            bar_even,
    output logic [15:0]            bar_odd,
    output logic                   last_pair
);
    import sbs_pkg::*;

    localparam int BW = $clog2(BAR_COUNT);

    typedef struct packed {
        logic                store_en;
        logic [AW-1:0]       addr;
        logic [VALUE_W-1:0]  value;
        logic                frame_en;
        logic [CW-1:0]       len;
        logic [VALUE_W-1:0]  low;
        logic [RANGE_W-1:0]  range;
        logic                clr;
        logic [CW-1:0]       pool_w;
    } cmd_t;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_NORM = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_MUL1 = 4'd4;
    localparam logic [3:0] S_MUL2 = 4'd5;
    localparam logic [3:0] S_WR   = 4'd6;
    localparam logic [3:0] S_PRD  = 4'd7;
    localparam logic [3:0] S_PCMP = 4'd8;
    localparam logic [3:0] S_PBAR = 4'd9;

    cmd_t c;
    assign c = cmd;

    logic [VALUE_W-1:0] bin_mem [MAX_BINS];
    logic [LEVEL_W-1:0] lvl_mem [MAX_BINS];
    logic [VALUE_W-1:0] bin_rd_reg;
    logic [LEVEL_W-1:0] lvl_rd_reg;

    logic [3:0]          state_reg;
    logic [CW-1:0]       len_reg, cell_reg, ptr_reg, j_reg;
    logic [VALUE_W-1:0]  low_reg;
    logic [RANGE_W-1:0]  range_reg, rem_reg;
    logic                zero_lv_reg;
    logic [LEVEL_W-1:0]  q_reg, lv_reg, acc_reg, even_reg;
    logic [3:0]          div_cnt_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic [31:0]         m1_reg;
    logic [32:0]         m2_reg;
    logic [BW-1:0]       b_reg;
    logic                res_valid_reg, res_last_reg;
    logic [15:0]         res_even_reg, res_odd_reg;

    logic signed [RANGE_W-1:0] d;
    logic [RANGE_W:0]    rem2;
    logic                ge;
    logic [33:0]         sum;
    logic [LEVEL_W-1:0]  lv_eff, new_lvl;
    logic [CW-1:0]       ptr_inc, j_inc;
    logic [AW-1:0]       raddr;

    assign pop     = (state_reg == S_IDLE) && cmd_valid;
    assign raddr   = ptr_reg[AW-1:0];
    assign lv_eff  = zero_lv_reg ? '0 : lvl_rd_reg;
    assign d       = $signed({bin_rd_reg[31], bin_rd_reg}) - $signed({low_reg[31], low_reg});
    assign rem2    = {rem_reg, 1'b0};
    assign ge      = (rem2 >= {1'b0, range_reg});
    assign sum     = {2'b0, m1_reg} + {1'b0, m2_reg} + ROUND_HALF;
    assign new_lvl = sum[31:16];
    assign ptr_inc = ptr_reg + CW'(1);
    assign j_inc   = j_reg + CW'(1);

    always_ff @(posedge clk)
    begin
        bin_rd_reg <= bin_mem[raddr];
        lvl_rd_reg <= lvl_mem[raddr];
        if (pop && c.store_en)
        begin
            bin_mem[c.addr] <= c.value;
        end
        if (state_reg == S_WR)
        begin
            lvl_mem[raddr] <= new_lvl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            zero_lv_reg   <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop && c.frame_en)
                    begin
                        len_reg   <= c.len;
                        cell_reg  <= c.pool_w;
                        low_reg   <= c.low;
                        range_reg <= c.range;
                        ptr_reg   <= '0;
                        j_reg     <= '0;
                        b_reg     <= '0;
                        acc_reg   <= '0;
                        if (c.clr)
                        begin
                            zero_lv_reg <= 1'b1;
                        end
                        state_reg <= (c.range != '0) ? S_RD : S_PRD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_NORM;
                end
                S_NORM:
                begin
                    lv_reg <= lv_eff;
                    if (d < 0)
                    begin
                        q_reg     <= '0;
                        state_reg <= S_MUL1;
                    end
                    else if (d >= $signed(range_reg))
                    begin
                        q_reg     <= LEVEL_MAX;
                        state_reg <= S_MUL1;
                    end
                    else
                    begin
                        rem_reg     <= d;
                        div_cnt_reg <= '0;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // restoring division, one quotient bit per cycle
                    rem_reg     <= ge ? RANGE_W'(rem2 - {1'b0, range_reg}) : rem2[RANGE_W-1:0];
                    q_reg       <= {q_reg[LEVEL_W-2:0], ge};
                    div_cnt_reg <= div_cnt_reg + 4'd1;
                    if (div_cnt_reg == 4'd15)
                    begin
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1:
                begin
                    w_reg     <= (q_reg > lv_reg) ? attack_weight : decay_weight;
                    m1_reg    <= 32'((q_reg > lv_reg) ? attack_weight : decay_weight)
                                 * 32'(q_reg);
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    m2_reg    <= 33'(WEIGHT_ONE - {1'b0, w_reg}) * 33'(lv_reg);
                    state_reg <= S_WR;
                end
                S_WR:
                begin
                    if (ptr_inc == len_reg)
                    begin
                        zero_lv_reg <= 1'b0;
                        ptr_reg     <= '0;
                        state_reg   <= S_PRD;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_inc;
                        state_reg <= S_RD;
                    end
                end
                S_PRD:
                begin
                    state_reg <= S_PCMP;
                end
                S_PCMP:
                begin
                    if (lv_eff > acc_reg)
                    begin
                        acc_reg <= lv_eff;
                    end
                    ptr_reg <= ptr_inc;
                    j_reg   <= j_inc;
                    state_reg <= (j_inc == cell_reg || ptr_inc >= len_reg) ? S_PBAR : S_PRD;
                end
                S_PBAR:
                begin
                    if (!b_reg[0] && b_reg != BW'(BAR_COUNT - 1))
                    begin
                        even_reg <= acc_reg;
                    end
                    else
                    begin
                        res_valid_reg <= 1'b1;
                        res_even_reg  <= b_reg[0] ? even_reg : acc_reg;
                        res_odd_reg   <= b_reg[0] ? acc_reg : '0;
                        res_last_reg  <= (b_reg == BW'(BAR_COUNT - 1));
                    end
                    if (b_reg == BW'(BAR_COUNT - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        b_reg     <= b_reg + BW'(1);
                        acc_reg   <= '0;
                        j_reg     <= '0;
                        // bars past the frame end read as zero
                        state_reg <= (ptr_reg >= len_reg) ? S_PBAR : S_PRD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = res_valid_reg;
    assign bar_even     = res_even_reg;
    assign bar_odd      = res_odd_reg;
    assign last_pair    = res_last_reg;
endmodule
`default_nettype wire

/* design/spectrum_bar_smoother_core.sv */
// ----------------------------------------------------------------------------
// spectrum_bar_smoother_core
// frame-wise bin normalize, attack/decay smoothing and bar pooling
// ----------------------------------------------------------------------------
// A bin is taken and queued; the back end stores it when it pops the
// command. On the final bin the back end walks all stored bins. When the
// range is nonzero each bin is read, normalized, run through 16 steps of
// the serial divider and two multiplies and written back; a bin that falls
// outside the range clamps and skips the divider. Pooling then reads and
// compares each bin and closes each bar. busy rises only when the two-word
// command queue is full. Results come out on result_valid for one cycle
// each and must be taken then; the receiver cannot stall the block.
`default_nettype none
module spectrum_bar_smoother_core #(
    parameter int MAX_BINS  = 1024,
    parameter int BAR_COUNT = 120
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] bin_value,
    input  wire logic               last_bin,
    input  wire logic               song_start,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [15:0]        cfg_data,
    output logic                    result_valid,
    output logic [15:0]             bar_even,
    output logic [15:0]             bar_odd,
    output logic                    last_pair
);
    import sbs_pkg::*;

    localparam int AW    = $clog2(MAX_BINS);
    localparam int CW    = $clog2(MAX_BINS + 1);
    localparam int CMD_W = 1 + AW + VALUE_W + 1 + CW + VALUE_W + RANGE_W + 1 + CW;

    logic [15:0]      attack_reg, decay_reg;
    logic             accept, push, pop, not_empty, full;
    logic [CMD_W-1:0] cmd_in, cmd_head;

    assign busy   = full;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg <= ATTACK_RESET;
            decay_reg  <= DECAY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ATTACK: attack_reg <= cfg_data;
                CFG_DECAY:  decay_reg  <= cfg_data;
                default:    attack_reg <= attack_reg;
            endcase
        end
    end

    sbs_front #(
        .MAX_BINS  (MAX_BINS),
        .BAR_COUNT (BAR_COUNT),
        .AW        (AW),
        .CW        (CW),
        .CMD_W     (CMD_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .bin_value  (bin_value),
        .last_bin   (last_bin),
        .song_start (song_start),
        .push       (push),
        .cmd        (cmd_in)
    );

    sbs_cmd_fifo #(
        .W (CMD_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cmd_in),
        .pop       (pop),
        .not_empty (not_empty),
        .full      (full),
        .head      (cmd_head)
    );

    sbs_back #(
        .MAX_BINS  (MAX_BINS),
        .BAR_COUNT (BAR_COUNT),
        .AW        (AW),
        .CW        (CW),
        .CMD_W     (CMD_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (not_empty),
        .cmd           (cmd_head),
        .pop           (pop),
        .attack_weight (attack_reg),
        .decay_weight  (decay_reg),
        .result_valid  (result_valid),
        .bar_even      (bar_even),
        .bar_odd       (bar_odd),
        .last_pair     (last_pair)
    );
endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for spectrum_bar_smoother_core: frames of bins go in
// through the bin input, bar pairs are predicted per frame and compared
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    import sbs_pkg::*;

    localparam int NUM_BINS = 1024;
    localparam int NUM_BARS = 120;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [15:0] even;
        logic [15:0] odd;
        logic        last;
    } bar_pair_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] bin_value = '0;
    logic               last_bin = 1'b0;
    logic               song_start = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = CFG_ATTACK;
    logic [15:0]        cfg_data = '0;
    logic               result_valid;
    logic [15:0]        bar_even;
    logic [15:0]        bar_odd;
    logic               last_pair;

    // predictor state
    logic signed [31:0] bins_mem [NUM_BINS];
    logic [15:0]        levels [NUM_BINS];
    logic signed [31:0] hi_mark;
    logic signed [31:0] lo_mark;
    int                 fill;
    int                 prev_len;
    logic [15:0]        w_attack;
    logic [15:0]        w_decay;

    bar_pair_t          pending_pairs[$];
    int                 errors = 0;
    int                 cycles = 0;
    logic               took;
    logic               steady = 1'b0;

    spectrum_bar_smoother_core u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .bin_value(bin_value), .last_bin(last_bin), .song_start(song_start),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .result_valid(result_valid), .bar_even(bar_even), .bar_odd(bar_odd),
        .last_pair(last_pair)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // word taken at this edge, read back at the next falling edge
    always @(posedge clk)
        took <= start && !busy;

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        begin
            $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        bar_pair_t want;
        if (rst_n && result_valid)
        begin
            if (pending_pairs.size() == 0)
                report("unexpected word", bar_even, 16'h0);
            else
            begin
                want = pending_pairs.pop_front();
                if (bar_even !== want.even) report("bar_even", bar_even, want.even);
                if (bar_odd !== want.odd) report("bar_odd", bar_odd, want.odd);
                if (last_pair !== want.last)
                    report("last_pair", {15'd0, last_pair}, {15'd0, want.last});
            end
        end
    end

    function automatic logic [15:0] blend(input logic [15:0] w, input longint n,
                                          input logic [15:0] lvl);
        longint s;
        begin
            s = longint'(w) * n + (65536 - longint'(w)) * longint'(lvl) + 32768;
            return 16'(s >> 16);
        end
    endfunction

    task automatic predict_bin(input logic signed [31:0] v, input logic lastf,
                               input logic startf);
        int len;
        int pool_w;
        int base;
        longint span;
        longint d;
        longint n;
        logic [15:0] bars [2];
        bar_pair_t pr;
        begin
            if (startf)
            begin
                hi_mark = 0;
                lo_mark = 0;
            end
            if (fill < NUM_BINS)
            begin
                bins_mem[fill] = v;
                fill++;
                if (v > hi_mark) hi_mark = v;
                if (v < lo_mark) lo_mark = v;
            end
            if (lastf)
            begin
                len = fill;
                fill = 0;
                if (len != prev_len)
                    foreach (levels[i]) levels[i] = '0;
                prev_len = len;
                span = longint'(hi_mark) - longint'(lo_mark);
                if (span > 0)
                    for (int i = 0; i < len; i++)
                    begin
                        d = longint'(bins_mem[i]) - longint'(lo_mark);
                        if (d < 0) d = 0;
                        n = (d << 16) / span;
                        if (n > 65535) n = 65535;
                        if (n > longint'(levels[i]))
                            levels[i] = blend(w_attack, n, levels[i]);
                        else
                            levels[i] = blend(w_decay, n, levels[i]);
                    end
                pool_w = len / NUM_BARS;
                if (pool_w == 0) pool_w = 1;
                for (int b = 0; b < NUM_BARS; b += 2)
                begin
                    for (int k = 0; k < 2; k++)
                    begin
                        bars[k] = '0;
                        base = (b + k) * pool_w;
                        if (b + k < NUM_BARS && base < len)
                        begin
                            bars[k] = levels[base];
                            for (int j = 1; j < pool_w && base + j < len; j++)
                                if (levels[base + j] > bars[k]) bars[k] = levels[base + j];
                        end
                    end
                    pr.even = bars[0];
                    pr.odd = bars[1];
                    pr.last = (b + 2 >= NUM_BARS);
                    pending_pairs.push_back(pr);
                end
            end
        end
    endtask

    // called and left at a falling edge
    task automatic send_word(input logic signed [31:0] v, input logic lastf,
                             input logic startf);
        begin
            if (!steady && $urandom_range(99) < 24)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            start <= 1'b1;
            bin_value <= v;
            last_bin <= lastf;
            song_start <= startf;
            do @(negedge clk); while (!took);
            predict_bin(v, lastf, startf);
        end
    endtask

    task automatic drain;
        begin
            start <= 1'b0;
            @(negedge clk);
            while (pending_pairs.size() != 0) @(negedge clk);
            repeat (50) @(negedge clk);
        end
    endtask

    task automatic write_weight(input logic idx, input logic [15:0] val);
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            @(negedge clk);
            cfg_we <= 1'b0;
            @(negedge clk);
            if (idx == CFG_ATTACK) w_attack = val; else w_decay = val;
        end
    endtask

    function automatic logic signed [31:0] rand_bin();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(4000)) - 2000;
            2: return $urandom_range(1000000);
            default: return -$signed($urandom_range(32'h3fffffff));
        endcase
    endfunction

    task automatic send_frame(input int len, input logic restart);
        begin
            for (int i = 0; i < len; i++)
                send_word(rand_bin(), i == len - 1, restart && i == 0);
        end
    endtask

    task automatic test_corners;
        begin
            send_word(32'sh7fffffff, 1'b0, 1'b0);
            send_word(32'sh80000000, 1'b1, 1'b0);
            send_word(32'sh7fffffff, 1'b0, 1'b0);
            send_word(32'sh80000000, 1'b1, 1'b0);
            // zero range: single zero bin right after a song start
            send_word(32'sh0, 1'b1, 1'b1);
            send_word(32'sh0, 1'b1, 1'b1);
            // range cleared mid frame: earlier bins fall outside and clamp
            send_word(32'sh00100000, 1'b0, 1'b0);
            send_word(-32'sh00100000, 1'b0, 1'b0);
            send_word(32'sh00000100, 1'b0, 1'b1);
            send_word(-32'sh00000080, 1'b1, 1'b0);
            send_word(32'sh00000300, 1'b0, 1'b0);
            send_word(32'sh00000100, 1'b0, 1'b0);
            send_word(-32'sh00000080, 1'b0, 1'b0);
            send_word(32'sh00000040, 1'b1, 1'b0);
            send_word(32'sh00000001, 1'b0, 1'b1);
            send_word(32'sh00000000, 1'b0, 1'b0);
            send_word(32'sh00000001, 1'b0, 1'b0);
            send_word(32'sh00000000, 1'b1, 1'b0);
            drain();
        end
    endtask

    task automatic test_weights;
        logic [15:0] pick [3];
        begin
            pick = '{16'h0000, 16'hffff, 16'h8000};
            for (int a = 0; a < 3; a++)
            begin
                write_weight(CFG_ATTACK, pick[a]);
                write_weight(CFG_DECAY, pick[2 - a]);
                repeat (3) send_frame(4, 1'b0);
                drain();
            end
            write_weight(CFG_ATTACK, ATTACK_RESET);
            write_weight(CFG_DECAY, DECAY_RESET);
        end
    endtask

    task automatic test_random;
        int sent;
        int len;
        begin
            sent = 0;
            while (sent < 100)
            begin
                if (sent >= 30 && sent < 70) steady = 1'b1; else steady = 1'b0;
                len = ($urandom_range(3) == 0) ? $urandom_range(1, 12) : 5;
                send_frame(len, $urandom_range(9) == 0);
                sent += len;
                if ($urandom_range(7) == 0)
                begin
                    drain();
                    write_weight(CFG_ATTACK, 16'($urandom));
                    write_weight(CFG_DECAY, 16'($urandom));
                end
            end
            steady = 1'b0;
            drain();
        end
    endtask

    initial
    begin
        foreach (bins_mem[i]) bins_mem[i] = '0;
        foreach (levels[i]) levels[i] = '0;
        hi_mark = 0;
        lo_mark = 0;
        fill = 0;
        prev_len = 0;
        w_attack = ATTACK_RESET;
        w_decay = DECAY_RESET;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_corners();
        test_weights();
        test_random();
        repeat (200) @(negedge clk);
        if (errors == 0 && pending_pairs.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

/* spectrum_bar_smoother_core.f */
design/sbs_pkg.sv
design/sbs_cmd_fifo.sv
design/sbs_front.sv
design/sbs_back.sv
design/spectrum_bar_smoother_core.sv
tb/sv/tb.sv
